FILE: rtl/jfps_pkg.sv
// ----------------------------------------------------------------------------
// jfps_pkg
// Shared constants, types and arithmetic for the five-point stencil block.
// ----------------------------------------------------------------------------
package jfps_pkg;

    localparam int MAX_WIDTH        = 1024;
    localparam int SAMPLE_BITS      = 32;

    localparam int COL_W            = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int WID_W            = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W            = 16;
    localparam int GRID_WIDTH_BITS  = 11;
    localparam int GRID_HEIGHT_BITS = 16;
    localparam int OUT_COL_BITS     = 10;
    localparam int CFG_INDEX_BITS   = 2;
    localparam int CFG_DATA_BITS    = 16;
    localparam int MIN_DIM          = 3;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_GRID_WIDTH  = 2'd0,
        CFG_GRID_HEIGHT = 2'd1
    } t_cfg_index;

    // one accepted word waiting for its line store reads
    typedef struct packed {
        logic             has_res;
        logic             last;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        t_sample          sample;
    } t_s1;

    // floor((a + b + c + d) / 4) formed at full width, kept to sample width
    function automatic t_sample quarter_sum(input t_sample a, input t_sample b,
                                            input t_sample c, input t_sample d);
        logic signed [SAMPLE_BITS+1:0] sum;
        sum = (SAMPLE_BITS+2)'(a) + (SAMPLE_BITS+2)'(b)
            + (SAMPLE_BITS+2)'(c) + (SAMPLE_BITS+2)'(d);
        return t_sample'(sum >>> 2);
    endfunction

    function automatic logic [WID_W-1:0] clamp_width(input logic [GRID_WIDTH_BITS-1:0] v);
        if (32'(v) < MIN_DIM) begin
            return WID_W'(MIN_DIM);
        end else if (32'(v) > MAX_WIDTH) begin
            return WID_W'(MAX_WIDTH);
        end
        return WID_W'(v);
    endfunction

    function automatic logic [ROW_W-1:0] clamp_height(input logic [GRID_HEIGHT_BITS-1:0] v);
        if (32'(v) < MIN_DIM) begin
            return ROW_W'(MIN_DIM);
        end
        return ROW_W'(v);
    endfunction

endpackage

FILE: rtl/jfps_ram.sv
// ----------------------------------------------------------------------------
// jfps_ram
// Generic one-write, one-read RAM with registered, read-first output.
// ----------------------------------------------------------------------------
module jfps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns the old word when both ports hit one address
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/jfps_cell.sv
// ----------------------------------------------------------------------------
// jfps_cell
// One window tap: holds a sample and takes its neighbor's on advance.
// ----------------------------------------------------------------------------
module jfps_cell
    import jfps_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  t_sample i_d,
    output t_sample o_q
);

    t_sample r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else if (i_en) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

FILE: rtl/jacobi_five_point_stencil_top.sv
// ----------------------------------------------------------------------------
// jacobi_five_point_stencil_top
// Streams a grid in raster order and emits the Jacobi update of each
// interior point from two line stores and a chain of window cells.
// ----------------------------------------------------------------------------
//  channel | valid       | ready        | payload
//  --------+-------------+--------------+-------------------------------------
//  input   | i_in_valid  | o_in_ready   | i_sample
//  output  | o_out_valid | i_out_ready  | o_result_value, o_out_row,
//          |             |              | o_out_col, o_last_result
//  config  | i_cfg_valid | o_cfg_ready  | i_cfg_index, i_cfg_data
//
//  One sample word is taken per cycle while the output does not stall; a
//  result passes the registered line store read and then the output
//  register. Reset restores a 1024 by 1024 grid and clears the counters;
//  line store contents are not cleared. A stalled output holds one result
//  while one more word sits in the read stage, then input stalls.
// ----------------------------------------------------------------------------
module jacobi_five_point_stencil_top
    import jfps_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  t_sample                   i_sample,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output t_sample                   o_result_value,
    output logic [ROW_W-1:0]          o_out_row,
    output logic [OUT_COL_BITS-1:0]   o_out_col,
    output logic                      o_last_result,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data
);

    logic [WID_W-1:0] r_eff_w;
    logic [ROW_W-1:0] r_eff_h;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;

    logic             r_v1;
    t_s1              r_s1;
    logic             r_v2;
    t_sample          r_res;
    logic [ROW_W-1:0] r_orow;
    logic [OUT_COL_BITS-1:0] r_ocol;
    logic             r_olast;

    logic in_acc, cfg_acc, cfg_hit, adv1, s2_free, load2;
    logic last_col, last_row;
    t_sample above_rd, two_rd, w0, w1, w2, sum_q;
    logic [COL_W-1:0] north_raddr, two_waddr, col_m1;
    t_s1 s1_in;

    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;

    always_comb begin
        unique case (i_cfg_index)
            CFG_GRID_WIDTH, CFG_GRID_HEIGHT: cfg_hit = 1'b1;
            default:                         cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff_w <= WID_W'(MAX_WIDTH);
            r_eff_h <= ROW_W'(1024);
        end else if (cfg_acc) begin
            unique case (i_cfg_index)
                CFG_GRID_WIDTH:  r_eff_w <= clamp_width(i_cfg_data[GRID_WIDTH_BITS-1:0]);
                CFG_GRID_HEIGHT: r_eff_h <= clamp_height(i_cfg_data[GRID_HEIGHT_BITS-1:0]);
                default: ;
            endcase
        end
    end

    // pipeline handshake
    assign s2_free    = !r_v2 || i_out_ready;
    assign adv1       = r_v1 && (!r_s1.has_res || s2_free);
    assign load2      = adv1 && r_s1.has_res;
    assign o_in_ready = !r_v1 || adv1;
    assign in_acc     = i_in_valid && o_in_ready;

    assign last_col = (32'(r_col) + 1 >= 32'(r_eff_w));
    assign last_row = (32'(r_row) + 1 >= 32'(r_eff_h));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (cfg_acc && cfg_hit) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            if (last_col) begin
                r_col <= '0;
                r_row <= last_row ? '0 : r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    always_comb begin
        s1_in.has_res = (r_row >= ROW_W'(2)) && (32'(r_col) >= 2);
        s1_in.last    = last_row && last_col;
        s1_in.col     = r_col;
        s1_in.row     = r_row;
        s1_in.sample  = i_sample;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (o_in_ready) begin
            r_v1 <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1 <= s1_in;
        end
    end

    // line stores
    assign north_raddr = (r_col == '0) ? '0 : r_col - 1'b1;
    assign two_waddr   = r_s1.col - 1'b1;

    jfps_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WIDTH)) u_above_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (r_col),
        .i_wdata (i_sample),
        .i_re    (in_acc),
        .i_raddr (r_col),
        .o_rdata (above_rd)
    );

    // delayed copy of the row above
    jfps_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WIDTH)) u_two_above_ram (
        .i_clk   (i_clk),
        .i_we    (adv1 && (r_s1.col != '0)),
        .i_waddr (two_waddr),
        .i_wdata (w1),
        .i_re    (in_acc),
        .i_raddr (north_raddr),
        .o_rdata (two_rd)
    );

    // window: south tap, then two taps of the row above
    jfps_cell u_cell_south (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (adv1), .i_d (r_s1.sample), .o_q (w0)
    );
    jfps_cell u_cell_above1 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (adv1), .i_d (above_rd), .o_q (w1)
    );
    jfps_cell u_cell_above2 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (adv1), .i_d (w1), .o_q (w2)
    );

    assign sum_q  = quarter_sum(above_rd, w2, two_rd, w0);
    assign col_m1 = r_s1.col - 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (load2) begin
            r_v2 <= 1'b1;
        end else if (i_out_ready) begin
            r_v2 <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load2) begin
            r_res   <= sum_q;
            r_orow  <= r_s1.row - 1'b1;
            r_ocol  <= OUT_COL_BITS'(col_m1);
            r_olast <= r_s1.last;
        end
    end

    assign o_out_valid    = r_v2;
    assign o_result_value = r_res;
    assign o_out_row      = r_orow;
    assign o_out_col      = r_ocol;
    assign o_last_result  = r_olast;

    // checks
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_col) < 32'(r_eff_w))
        else $error("column counter beyond grid width");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row < r_eff_h)
        else $error("row counter beyond grid height");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load2 |-> (!r_v2 || i_out_ready))
        else $error("pending result overwritten");

    a_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_row != '0) && (o_out_col != '0))
        else $error("result for a border point");

endmodule
